// ===== rtl/q6k_pkg.sv =====
package q6k_pkg;

    localparam int DOT_W = 18;
    localparam int GROUPS = 4;
    localparam int LANES = 4;
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT = 32'h00400000;

    typedef enum logic {
        FP_MUL,
        FP_ADD
    } fp_op_t;

    typedef struct packed {
        logic        valid;
        fp_op_t      op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    // fp16 bit pattern to single, exact
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] q;
        logic [7:0] e;
        logic [9:0] nm;
        logic [31:0] r;
        s = h[15];
        ex = h[14:10];
        man = h[9:0];
        q = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                q = 4'(i);
            end
        end
        e = 8'(q) + 8'd103;
        nm = 10'(man << (4'd10 - q));
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                r = {s, 31'b0};
            end
            else
            begin
                r = {s, e, nm, 13'b0};
            end
        end
        else if (ex == 5'h1F)
        begin
            r = {s, 8'hFF, man, 13'b0};
        end
        else
        begin
            r = {s, 8'(ex) + 8'd112, man, 13'b0};
        end
        return r;
    endfunction

    // small signed integer to single, exact
    function automatic logic [31:0] int_to_single(input logic signed [DOT_W-1:0] v);
        logic [DOT_W-1:0] mag;
        logic [4:0]       p;
        logic [40:0]      t;
        logic [31:0]      r;
        mag = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
        p = '0;
        for (int i = 0; i < DOT_W; i++)
        begin
            if (mag[i])
            begin
                p = 5'(i);
            end
        end
        t = 41'(mag) << (5'd23 - p);
        if (mag == '0)
        begin
            r = 32'h0;
        end
        else
        begin
            r = {v[DOT_W-1], 8'd127 + 8'(p), t[22:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/q6k_item_if.sv =====
interface q6k_item_if;
    logic        valid;
    logic        ready;
    logic [63:0] nibbles_first;
    logic [63:0] nibbles_second;
    logic [63:0] high_plane;
    logic [15:0] super_scale;
    logic signed [7:0] scale_first_half;
    logic signed [7:0] scale_second_half;
    logic [63:0] acts_a;
    logic [63:0] acts_b;
    logic [63:0] acts_c;
    logic [63:0] acts_d;
    logic [31:0] act_scale;
    logic        last_block;

    modport source (
        output valid, nibbles_first, nibbles_second, high_plane, super_scale,
               scale_first_half, scale_second_half, acts_a, acts_b, acts_c, acts_d,
               act_scale, last_block,
        input  ready
    );
    modport sink (
        input  valid, nibbles_first, nibbles_second, high_plane, super_scale,
               scale_first_half, scale_second_half, acts_a, acts_b, acts_c, acts_d,
               act_scale, last_block,
        output ready
    );
endinterface

// ===== rtl/q6k_result_if.sv =====
interface q6k_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_value;

    modport source (
        output valid, dot_value,
        input  ready
    );
    modport sink (
        input  valid, dot_value,
        output ready
    );
endinterface

// ===== rtl/q6k_dot.sv =====
module q6k_dot
    import q6k_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [127:0]            nib,
    input  logic [63:0]             plane,
    input  logic [255:0]            acts,
    output logic                    busy,
    output logic signed [DOT_W-1:0] dot0,
    output logic signed [DOT_W-1:0] dot1
);

    logic                    busy_reg;
    logic [1:0]              grp_reg;
    logic signed [DOT_W-1:0] dot0_reg;
    logic signed [DOT_W-1:0] dot1_reg;
    logic signed [DOT_W-1:0] part0;
    logic signed [DOT_W-1:0] part1;

    // one group of four weights per half each cycle
    always_comb
    begin
        logic [31:0] word;
        logic [7:0]  hb0;
        logic [7:0]  hb1;
        logic [31:0] a0;
        logic [31:0] a1;
        logic signed [6:0] w0;
        logic signed [6:0] w1;
        word = nib[{grp_reg, 5'b0} +: 32];
        hb0 = plane[{grp_reg, 4'b0} +: 8];
        hb1 = plane[{grp_reg, 4'b1000} +: 8];
        a0 = acts[{1'b0, grp_reg, 5'b0} +: 32];
        a1 = acts[{1'b1, grp_reg, 5'b0} +: 32];
        part0 = '0;
        part1 = '0;
        for (int k = 0; k < LANES; k++)
        begin
            w0 = $signed({1'b0, hb0[2*k +: 2], word[8*k +: 4]}) - 7'sd32;
            w1 = $signed({1'b0, hb1[2*k +: 2], word[8*k+4 +: 4]}) - 7'sd32;
            part0 = part0 + DOT_W'(w0 * $signed(a0[8*k +: 8]));
            part1 = part1 + DOT_W'(w1 * $signed(a1[8*k +: 8]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            grp_reg <= '0;
        end
        else if (busy_reg)
        begin
            grp_reg <= grp_reg + 2'd1;
            if (grp_reg == 2'(GROUPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dot0_reg <= '0;
            dot1_reg <= '0;
        end
        else if (busy_reg)
        begin
            dot0_reg <= dot0_reg + part0;
            dot1_reg <= dot1_reg + part1;
        end
    end

    assign busy = busy_reg;
    assign dot0 = dot0_reg;
    assign dot1 = dot1_reg;

endmodule

// ===== rtl/q6k_fpu.sv =====
module q6k_fpu
    import q6k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpu_req_t    req,
    output logic        res_valid,
    output logic [31:0] res
);

    logic               v1_reg;
    logic               s1_reg;
    logic               zs1_reg;
    logic [50:0]        m1_reg;
    logic signed [11:0] t1_reg;
    logic               spec1_reg;
    logic [31:0]        specv1_reg;
    logic               res_valid_reg;
    logic [31:0]        res_reg;

    logic               s_next;
    logic               zs_next;
    logic [50:0]        m_next;
    logic signed [11:0] t_next;
    logic               spec_next;
    logic [31:0]        specv_next;
    logic [31:0]        pack_next;

    // operand unpack, multiply or align and add
    always_comb
    begin
        logic        sa, sb, sx, sy;
        logic [7:0]  ea, eb, ex, ey, dd;
        logic [23:0] ma, mb, mx, my;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [50:0] ax, byf, bys;
        logic        stk;
        sa = req.a[31];
        sb = req.b[31];
        ea = (req.a[30:23] == 8'd0) ? 8'd1 : req.a[30:23];
        eb = (req.b[30:23] == 8'd0) ? 8'd1 : req.b[30:23];
        ma = {req.a[30:23] != 8'd0, req.a[22:0]};
        mb = {req.b[30:23] != 8'd0, req.b[22:0]};
        nan_a = (req.a[30:23] == 8'hFF) && (req.a[22:0] != 23'd0);
        nan_b = (req.b[30:23] == 8'hFF) && (req.b[22:0] != 23'd0);
        inf_a = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
        inf_b = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
        zero_a = req.a[30:0] == 31'd0;
        zero_b = req.b[30:0] == 31'd0;
        if (req.a[30:0] >= req.b[30:0])
        begin
            sx = sa; sy = sb; ex = ea; ey = eb; mx = ma; my = mb;
        end
        else
        begin
            sx = sb; sy = sa; ex = eb; ey = ea; mx = mb; my = ma;
        end
        dd = ex - ey;
        ax = {1'b0, mx, 26'b0};
        byf = {1'b0, my, 26'b0};
        bys = byf >> dd;
        stk = (bys << dd) != byf;
        spec_next = 1'b0;
        specv_next = QNAN_DEFAULT;
        if (req.op == FP_MUL)
        begin
            s_next = sa ^ sb;
            zs_next = sa ^ sb;
            m_next = 51'(ma * mb);
            t_next = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
            if (nan_a)
            begin
                spec_next = 1'b1;
                specv_next = req.a | QUIET_BIT;
            end
            else if (nan_b)
            begin
                spec_next = 1'b1;
                specv_next = req.b | QUIET_BIT;
            end
            else if ((inf_a && zero_b) || (inf_b && zero_a))
            begin
                spec_next = 1'b1;
                specv_next = QNAN_DEFAULT;
            end
            else if (inf_a || inf_b)
            begin
                spec_next = 1'b1;
                specv_next = {sa ^ sb, 8'hFF, 23'd0};
            end
        end
        else
        begin
            s_next = sx;
            zs_next = sa & sb;
            m_next = (sx ^ sy) ? (ax - (bys | 51'(stk))) : (ax + (bys | 51'(stk)));
            t_next = $signed({4'b0, ex}) - 12'sd176;
            if (nan_a)
            begin
                spec_next = 1'b1;
                specv_next = req.a | QUIET_BIT;
            end
            else if (nan_b)
            begin
                spec_next = 1'b1;
                specv_next = req.b | QUIET_BIT;
            end
            else if (inf_a && inf_b && (sa != sb))
            begin
                spec_next = 1'b1;
                specv_next = QNAN_DEFAULT;
            end
            else if (inf_a)
            begin
                spec_next = 1'b1;
                specv_next = req.a;
            end
            else if (inf_b)
            begin
                spec_next = 1'b1;
                specv_next = req.b;
            end
        end
    end

    // normalize and round to nearest even
    always_comb
    begin
        logic [5:0]         p;
        logic signed [11:0] e;
        logic signed [11:0] sh;
        logic [5:0]         shc;
        logic [114:0]       w;
        logic [23:0]        mant;
        logic               rnd, stk, inc, normal;
        logic [7:0]         ef;
        p = '0;
        for (int i = 0; i < 51; i++)
        begin
            if (m1_reg[i])
            begin
                p = 6'(i);
            end
        end
        e = $signed({6'b0, p}) + t1_reg + 12'sd127;
        normal = e >= 12'sd1;
        sh = normal ? ($signed({6'b0, p}) - 12'sd23) : -(t1_reg + 12'sd149);
        shc = (sh > 12'sd63) ? 6'd63 : sh[5:0];
        w = {m1_reg, 64'b0} >> shc;
        if (sh <= 12'sd0)
        begin
            mant = 24'(m1_reg << (-sh));
            rnd = 1'b0;
            stk = 1'b0;
        end
        else
        begin
            mant = w[87:64];
            rnd = w[63];
            stk = |w[62:0];
        end
        inc = rnd & (stk | mant[0]);
        ef = normal ? 8'(e - 12'sd1) : 8'd0;
        if (spec1_reg)
        begin
            pack_next = specv1_reg;
        end
        else if (m1_reg == '0)
        begin
            pack_next = {zs1_reg, 31'b0};
        end
        else if (e >= 12'sd255)
        begin
            pack_next = {s1_reg, 8'hFF, 23'd0};
        end
        else
        begin
            pack_next = {s1_reg, ({ef, 23'd0}) + 31'(mant) + 31'(inc)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            res_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s_next;
        zs1_reg <= zs_next;
        m1_reg <= m_next;
        t1_reg <= t_next;
        spec1_reg <= spec_next;
        specv1_reg <= specv_next;
        res_reg <= pack_next;
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

// ===== rtl/q6k_int8_dot_accumulator_unit.sv =====
// result: the sum is emitted and cleared after a sub-block flagged last_block
// a new sub-block is taken only when idle, after eight operations through one
// shared two-stage float unit, each issued and retired before the next
// the integer dots run on a four-lane unit beside the first float ops
// reset: asynchronous, active low; clears the sequencer, the output valid and the sum to +0.0
module q6k_int8_dot_accumulator_unit
    import q6k_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    q6k_item_if.sink          item,
    q6k_result_if.source      result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t      state_reg;
    logic [2:0]  op_reg;
    logic [127:0] nib_reg;
    logic [63:0] plane_reg;
    logic [255:0] acts_reg;
    logic [15:0] d_reg;
    logic [7:0]  s0_reg;
    logic [7:0]  s1_reg;
    logic [31:0] a_reg;
    logic        last_reg;
    logic [31:0] r0_reg;
    logic [31:0] r1_reg;
    logic [31:0] sum_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic                    accept;
    logic                    emit;
    logic                    dot_busy;
    logic signed [DOT_W-1:0] dot0;
    logic signed [DOT_W-1:0] dot1;
    fpu_req_t                fpu_req;
    logic                    fpu_res_valid;
    logic [31:0]             fpu_res;

    assign accept = item.valid && item.ready;
    assign item.ready = state_reg == S_IDLE;
    assign emit = state_reg == S_FINISH && last_reg && (!out_valid_reg || result.ready);

    q6k_dot u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .nib   (nib_reg),
        .plane (plane_reg),
        .acts  (acts_reg),
        .busy  (dot_busy),
        .dot0  (dot0),
        .dot1  (dot1)
    );

    // operand selection per sequencer step
    always_comb
    begin
        fpu_req.valid = state_reg == S_ISSUE;
        fpu_req.op = FP_MUL;
        case (op_reg)
            3'd0:
            begin
                fpu_req.a = half_to_single(d_reg);
                fpu_req.b = int_to_single(DOT_W'($signed(s0_reg)));
            end
            3'd1:
            begin
                fpu_req.a = half_to_single(d_reg);
                fpu_req.b = int_to_single(DOT_W'($signed(s1_reg)));
            end
            3'd2:
            begin
                fpu_req.a = r0_reg;
                fpu_req.b = a_reg;
            end
            3'd3:
            begin
                fpu_req.a = r1_reg;
                fpu_req.b = a_reg;
            end
            3'd4:
            begin
                fpu_req.a = r0_reg;
                fpu_req.b = int_to_single(dot0);
            end
            3'd5:
            begin
                fpu_req.a = r1_reg;
                fpu_req.b = int_to_single(dot1);
            end
            3'd6:
            begin
                fpu_req.op = FP_ADD;
                fpu_req.a = r0_reg;
                fpu_req.b = r1_reg;
            end
            default:
            begin
                fpu_req.op = FP_ADD;
                fpu_req.a = sum_reg;
                fpu_req.b = r0_reg;
            end
        endcase
    end

    q6k_fpu u_fpu (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (fpu_req),
        .res_valid (fpu_res_valid),
        .res       (fpu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= '0;
            sum_reg <= 32'h0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (fpu_res_valid)
                    begin
                        if (op_reg == 3'd7)
                        begin
                            sum_reg <= fpu_res;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            op_reg <= op_reg + 3'd1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (emit)
                    begin
                        out_data_reg <= sum_reg;
                        sum_reg <= 32'h0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload and intermediate products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nib_reg <= {item.nibbles_second, item.nibbles_first};
            plane_reg <= item.high_plane;
            acts_reg <= {item.acts_d, item.acts_c, item.acts_b, item.acts_a};
            d_reg <= item.super_scale;
            s0_reg <= item.scale_first_half;
            s1_reg <= item.scale_second_half;
            a_reg <= item.act_scale;
            last_reg <= item.last_block;
        end
        if (state_reg == S_WAIT && fpu_res_valid && op_reg != 3'd7)
        begin
            if (op_reg[0])
            begin
                r1_reg <= fpu_res;
            end
            else
            begin
                r0_reg <= fpu_res;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.dot_value = out_data_reg;

    a_dot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_req.valid && op_reg >= 3'd4 |-> !dot_busy)
        else $error("integer dot still running when its result is used");

    a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_res_valid |-> state_reg == S_WAIT)
        else $error("float result returned outside the wait step");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && last_reg && (!out_valid_reg || result.ready)
        |=> sum_reg == 32'h0 && result.valid)
        else $error("last sub-block did not emit and clear the sum");

    a_idle_dot: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !dot_busy)
        else $error("dot unit busy while accepting");

endmodule
